// ===== rtl/core/ssim_pkg.sv =====
`timescale 1ns / 1ps
package ssim_pkg;

   localparam int CMD_W = 2;
   localparam int POS_W = 31;
   localparam int FLAG_W = 8;
   localparam int IDX_W = 8;
   localparam int STATUS_W = 2;
   localparam int COUNT_OUT_W = 9;
   localparam int HIT_W = 1 + POS_W + FLAG_W;
   localparam int DEF_TABLE_DEPTH = 256;
   localparam int TREE_GROUP = 64;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT = 2'd0,
      CMD_READ   = 2'd1,
      CMD_CLEAR  = 2'd2,
      CMD_NOP    = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK     = 2'd0,
      ST_MERGED = 2'd1,
      ST_FULL   = 2'd2,
      ST_RANGE  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DONE
   } state_type;

   typedef struct packed {
      logic sample_insert;
      logic sample_read;
      logic shift;
      logic merge;
   } cell_ctrl_type;

   typedef struct packed {
      logic              found;
      logic [POS_W-1:0]  pos;
      logic [FLAG_W-1:0] flag;
   } hit_word_type;

endpackage

// ===== rtl/core/ssim_if.sv =====
`timescale 1ns / 1ps
interface ssim_req_if;
   import ssim_pkg::*;
   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  cmd;
   logic [POS_W-1:0]  site_pos;
   logic [FLAG_W-1:0] site_flag;
   logic [IDX_W-1:0]  read_index;
   modport source (output valid, cmd, site_pos, site_flag, read_index, input ready);
   modport sink (input valid, cmd, site_pos, site_flag, read_index, output ready);
endinterface

interface ssim_rsp_if;
   import ssim_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [STATUS_W-1:0]    status;
   logic [POS_W-1:0]       entry_pos;
   logic [FLAG_W-1:0]      entry_flag;
   logic [COUNT_OUT_W-1:0] entry_count;
   modport source (output valid, status, entry_pos, entry_flag, entry_count, input ready);
   modport sink (input valid, status, entry_pos, entry_flag, entry_count, output ready);
endinterface

// ===== rtl/core/ssim_cell.sv =====
`timescale 1ns / 1ps
module ssim_cell #(
   parameter int CELL_INDEX = 0,
   parameter int COUNT_W = 9,
   parameter int CMP_W = 9
) (
   input  logic                          clock,
   input  ssim_pkg::cell_ctrl_type       ctrl,
   input  logic [ssim_pkg::POS_W-1:0]    req_pos,
   input  logic [ssim_pkg::IDX_W-1:0]    req_index,
   input  logic [COUNT_W-1:0]            count,
   input  logic [ssim_pkg::POS_W-1:0]    ins_pos,
   input  logic [ssim_pkg::FLAG_W-1:0]   ins_flag,
   input  logic [ssim_pkg::POS_W-1:0]    left_pos,
   input  logic [ssim_pkg::FLAG_W-1:0]   left_flag,
   input  logic                          left_lt,
   output logic [ssim_pkg::POS_W-1:0]    pos,
   output logic [ssim_pkg::FLAG_W-1:0]   flag,
   output logic                          lt,
   output logic [ssim_pkg::HIT_W-1:0]    hit_word
);
   import ssim_pkg::*;

   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [FLAG_W-1:0] flag_ff, flag_in;
   logic              lt_ff, lt_in;
   logic              eq_ff, eq_in;
   logic              hit_ff, hit_in;
   logic              occupied;
   logic              eq_match;
   logic              sel_match;
   hit_word_type      word;

   assign occupied  = CMP_W'(CELL_INDEX) < CMP_W'(count);
   assign eq_match  = occupied && (pos_ff == req_pos);
   assign sel_match = occupied && (CMP_W'(CELL_INDEX) == CMP_W'(req_index));

   always_comb begin
      pos_in  = pos_ff;
      flag_in = flag_ff;
      lt_in   = lt_ff;
      eq_in   = eq_ff;
      hit_in  = hit_ff;
      if (ctrl.sample_insert || ctrl.sample_read) begin
         lt_in  = ctrl.sample_insert && occupied && (pos_ff < req_pos);
         eq_in  = ctrl.sample_insert && eq_match;
         hit_in = ctrl.sample_insert ? eq_match : sel_match;
      end
      // open a slot at the first entry not below the key, the rest move up
      if (ctrl.shift && !lt_ff) begin
         if (left_lt) begin
            pos_in  = ins_pos;
            flag_in = ins_flag;
         end else begin
            pos_in  = left_pos;
            flag_in = left_flag;
         end
      end
      if (ctrl.merge && eq_ff) begin
         flag_in = flag_ff | ins_flag;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff  <= pos_in;
      flag_ff <= flag_in;
      lt_ff   <= lt_in;
      eq_ff   <= eq_in;
      hit_ff  <= hit_in;
   end

   always_comb begin
      word.found = hit_ff;
      word.pos   = pos_ff;
      word.flag  = flag_ff;
   end

   assign pos      = pos_ff;
   assign flag     = flag_ff;
   assign lt       = lt_ff;
   assign hit_word = hit_ff ? HIT_W'(word) : '0;

endmodule

// ===== rtl/core/ssim_or_tree.sv =====
`timescale 1ns / 1ps
module ssim_or_tree #(
   parameter int DEPTH = ssim_pkg::DEF_TABLE_DEPTH
) (
   input  logic                       clock,
   input  logic [ssim_pkg::HIT_W-1:0] leaf [DEPTH],
   output logic [ssim_pkg::HIT_W-1:0] root
);
   import ssim_pkg::*;

   localparam int NUM_GROUPS = (DEPTH + TREE_GROUP - 1) / TREE_GROUP;
   localparam int PAD_DEPTH = NUM_GROUPS * TREE_GROUP;

   logic [HIT_W-1:0] leaf_pad [PAD_DEPTH];
   logic [HIT_W-1:0] grp_ff [NUM_GROUPS];
   logic [HIT_W-1:0] grp_in [NUM_GROUPS];

   for (genvar i = 0; i < PAD_DEPTH; i++) begin : g_pad
      if (i < DEPTH) begin : g_real
         assign leaf_pad[i] = leaf[i];
      end else begin : g_zero
         assign leaf_pad[i] = '0;
      end
   end

   for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_group
      always_comb begin
         grp_in[g] = '0;
         for (int j = 0; j < TREE_GROUP; j++) begin
            grp_in[g] = grp_in[g] | leaf_pad[g * TREE_GROUP + j];
         end
      end

      always_ff @(posedge clock) begin
         grp_ff[g] <= grp_in[g];
      end
   end

   always_comb begin
      root = '0;
      for (int g = 0; g < NUM_GROUPS; g++) begin
         root = root | grp_ff[g];
      end
   end

endmodule

// ===== rtl/core/sorted_site_insert_merge_unit.sv =====
`timescale 1ns / 1ps
// sorted site table with duplicate merge
// req_port carries one command word: insert a site (position and flag),
// read the entry at an index, or clear the table. rsp_port returns exactly
// one word per command: status, the read entry (zero unless a read hits)
// and the entry count after the command.
// the table is a row of cells, one per entry, kept in ascending position
// order; an insert compares in every cell at once, then each cell either
// keeps its entry, takes the new site, or takes its left neighbor's entry
// in a single shift step. a duplicate position ORs the flag in place.
// from acceptance to the response word a command passes the per-cell
// compares, the registered first level of the hit OR tree, and the final
// OR, the table update and the response load.
// a new command word is taken only after the previous one is done, as
// req_port.ready is high only while no command is in flight; it stays
// high while a finished response waits in the output register.
// if the receiver stalls with a response still held, the next command
// waits in its last step until the output register frees.
// reset (synchronous) empties the table and drops any pending response;
// the entries themselves are not cleared and need no clearing pass.
module sorted_site_insert_merge_unit #(
   parameter int TABLE_DEPTH = ssim_pkg::DEF_TABLE_DEPTH
) (
   input logic       clock,
   input logic       reset,
   ssim_req_if.sink   req_port,
   ssim_rsp_if.source rsp_port
);
   import ssim_pkg::*;

   localparam int COUNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int CMP_W = (COUNT_W > IDX_W) ? COUNT_W : IDX_W;

   state_type              state_ff, state_in;
   logic [COUNT_W-1:0]     count_ff, count_in;
   cmd_type                cmd_ff, cmd_in;
   logic [POS_W-1:0]       key_pos_ff, key_pos_in;
   logic [FLAG_W-1:0]      key_flag_ff, key_flag_in;
   logic                   in_range_ff, in_range_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   status_type             rsp_status_ff, rsp_status_in;
   logic [POS_W-1:0]       rsp_pos_ff, rsp_pos_in;
   logic [FLAG_W-1:0]      rsp_flag_ff, rsp_flag_in;
   logic [COUNT_OUT_W-1:0] rsp_count_ff, rsp_count_in;

   cell_ctrl_type    ctrl;
   logic             accept;
   cmd_type          req_cmd;
   hit_word_type     hit;
   logic [HIT_W-1:0] root;

   logic [POS_W-1:0]  cell_pos [TABLE_DEPTH];
   logic [FLAG_W-1:0] cell_flag [TABLE_DEPTH];
   logic              cell_lt [TABLE_DEPTH];
   logic [HIT_W-1:0]  cell_hit [TABLE_DEPTH];
   logic [POS_W-1:0]  left_pos [TABLE_DEPTH];
   logic [FLAG_W-1:0] left_flag [TABLE_DEPTH];
   logic              left_lt [TABLE_DEPTH];

   assign req_cmd = cmd_type'(req_port.cmd);
   assign req_port.ready = (state_ff == S_IDLE);
   assign accept  = req_port.valid && req_port.ready;
   assign hit     = hit_word_type'(root);

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_head
         assign left_pos[i]  = '0;
         assign left_flag[i] = '0;
         assign left_lt[i]   = 1'b1;
      end else begin : g_link
         assign left_pos[i]  = cell_pos[i-1];
         assign left_flag[i] = cell_flag[i-1];
         assign left_lt[i]   = cell_lt[i-1];
      end

      ssim_cell #(
         .CELL_INDEX (i),
         .COUNT_W    (COUNT_W),
         .CMP_W      (CMP_W)
      ) u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .req_pos   (req_port.site_pos),
         .req_index (req_port.read_index),
         .count     (count_ff),
         .ins_pos   (key_pos_ff),
         .ins_flag  (key_flag_ff),
         .left_pos  (left_pos[i]),
         .left_flag (left_flag[i]),
         .left_lt   (left_lt[i]),
         .pos       (cell_pos[i]),
         .flag      (cell_flag[i]),
         .lt        (cell_lt[i]),
         .hit_word  (cell_hit[i])
      );
   end

   ssim_or_tree #(
      .DEPTH (TABLE_DEPTH)
   ) u_or_tree (
      .clock (clock),
      .leaf  (cell_hit),
      .root  (root)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      key_pos_ff    <= key_pos_in;
      key_flag_ff   <= key_flag_in;
      in_range_ff   <= in_range_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_flag_ff   <= rsp_flag_in;
      rsp_count_ff  <= rsp_count_in;
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      cmd_in        = cmd_ff;
      key_pos_in    = key_pos_ff;
      key_flag_in   = key_flag_ff;
      in_range_in   = in_range_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_port.ready;
      rsp_status_in = rsp_status_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_flag_in   = rsp_flag_ff;
      rsp_count_in  = rsp_count_ff;
      ctrl          = '0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd_in             = req_cmd;
               key_pos_in         = req_port.site_pos;
               key_flag_in        = req_port.site_flag;
               in_range_in        = CMP_W'(req_port.read_index) < CMP_W'(count_ff);
               ctrl.sample_insert = (req_cmd == CMD_INSERT);
               ctrl.sample_read   = (req_cmd == CMD_READ);
               state_in           = S_SCAN;
            end
         end
         S_SCAN: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_port.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rsp_pos_in    = '0;
               rsp_flag_in   = '0;
               state_in      = S_IDLE;
               case (cmd_ff)
                  CMD_INSERT: begin
                     if (hit.found) begin
                        ctrl.merge    = 1'b1;
                        rsp_status_in = ST_MERGED;
                     end else if (count_ff == COUNT_W'(TABLE_DEPTH)) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        ctrl.shift = 1'b1;
                        count_in   = count_ff + 1'b1;
                     end
                  end
                  CMD_READ: begin
                     if (in_range_ff) begin
                        rsp_pos_in  = hit.pos;
                        rsp_flag_in = hit.flag;
                     end else begin
                        rsp_status_in = ST_RANGE;
                     end
                  end
                  CMD_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                  end
               endcase
               rsp_count_in = COUNT_OUT_W'(count_in);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_port.valid       = rsp_valid_ff;
   assign rsp_port.status      = rsp_status_ff;
   assign rsp_port.entry_pos   = rsp_pos_ff;
   assign rsp_port.entry_flag  = rsp_flag_ff;
   assign rsp_port.entry_count = rsp_count_ff;

endmodule

// ===== verif/tb_sorted_site_insert_merge_unit.sv =====
`timescale 1ns / 1ps
module tb_sorted_site_insert_merge_unit;
   import ssim_pkg::*;

   localparam int TABLE_DEPTH = DEF_TABLE_DEPTH;
   localparam int CYCLE_LIMIT = 200000;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int POOL_SIZE = 48;

   typedef struct {
      status_type             status;
      logic [POS_W-1:0]       pos;
      logic [FLAG_W-1:0]      flag;
      logic [COUNT_OUT_W-1:0] count;
   } site_reply_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ssim_req_if req_bus ();
   ssim_rsp_if rsp_bus ();

   sorted_site_insert_merge_unit #(.TABLE_DEPTH(TABLE_DEPTH)) uut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus)
   );

   // mirror of the sorted site table
   logic [POS_W-1:0]  mirror_pos [TABLE_DEPTH];
   logic [FLAG_W-1:0] mirror_flag [TABLE_DEPTH];
   int                mirror_count = 0;

   site_reply_type    expected_replies [$];
   logic [POS_W-1:0]  pos_pool [POOL_SIZE];
   int                error_count = 0;
   int                cycle_count = 0;
   int                burst_left = 0;
   bit                gaps_on = 1'b1;
   bit                hold_request = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout at cycle %0d", cycle_count);
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic report_mismatch(string what, longint unsigned want, longint unsigned got);
      $display("cycle %0d: %s expected %0h got %0h", cycle_count, what, want, got);
      error_count++;
   endtask

   function automatic site_reply_type predict_reply(cmd_type c, logic [POS_W-1:0] p,
                                                    logic [FLAG_W-1:0] f,
                                                    logic [IDX_W-1:0] i);
      site_reply_type r;
      int slot;
      bit merged;
      r.status = ST_OK;
      r.pos = '0;
      r.flag = '0;
      case (c)
         CMD_INSERT: begin
            slot = mirror_count;
            merged = 1'b0;
            while (slot > 0) begin
               if (mirror_pos[slot-1] == p) begin
                  mirror_flag[slot-1] = mirror_flag[slot-1] | f;
                  merged = 1'b1;
                  break;
               end
               if (mirror_pos[slot-1] < p) break;
               slot--;
            end
            if (merged) begin
               r.status = ST_MERGED;
            end else if (mirror_count >= TABLE_DEPTH) begin
               r.status = ST_FULL;
            end else begin
               for (int j = mirror_count; j > slot; j--) begin
                  mirror_pos[j] = mirror_pos[j-1];
                  mirror_flag[j] = mirror_flag[j-1];
               end
               mirror_pos[slot] = p;
               mirror_flag[slot] = f;
               mirror_count++;
            end
         end
         CMD_READ: begin
            if (int'(i) < mirror_count) begin
               r.pos = mirror_pos[i];
               r.flag = mirror_flag[i];
            end else begin
               r.status = ST_RANGE;
            end
         end
         CMD_CLEAR: mirror_count = 0;
         default: ;
      endcase
      r.count = mirror_count[COUNT_OUT_W-1:0];
      return r;
   endfunction

   // one word out, with bursts and random gaps afterwards
   task automatic send_word(cmd_type c, logic [POS_W-1:0] p, logic [FLAG_W-1:0] f,
                            logic [IDX_W-1:0] i);
      req_bus.valid <= 1'b1;
      req_bus.cmd <= c;
      req_bus.site_pos <= p;
      req_bus.site_flag <= f;
      req_bus.read_index <= i;
      do @(posedge clock); while (!req_bus.ready);
      expected_replies.push_back(predict_reply(c, p, f, i));
      if (gaps_on && burst_left == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(0, 8);
      end else if (burst_left > 0) begin
         burst_left--;
      end
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (expected_replies.size() != 0);
   endtask

   task automatic send_insert(logic [POS_W-1:0] p, logic [FLAG_W-1:0] f);
      send_word(CMD_INSERT, p, f, IDX_W'($urandom()));
   endtask

   task automatic send_read(logic [IDX_W-1:0] i);
      send_word(CMD_READ, POS_W'($urandom()), FLAG_W'($urandom()), i);
   endtask

   task automatic send_clear();
      send_word(CMD_CLEAR, POS_W'($urandom()), FLAG_W'($urandom()), IDX_W'($urandom()));
   endtask

   function automatic logic [IDX_W-1:0] pick_index();
      if (mirror_count > 0 && $urandom_range(0, 3) != 0)
         return IDX_W'($urandom_range(0, mirror_count - 1));
      return IDX_W'($urandom_range(0, 255));
   endfunction

   function automatic logic [POS_W-1:0] pick_pos();
      logic [POS_W-1:0] p;
      case ($urandom_range(0, 3))
         0, 1: p = pos_pool[$urandom_range(0, POOL_SIZE - 1)];
         2: p = pos_pool[$urandom_range(0, POOL_SIZE - 1)]
                + ($urandom_range(0, 1) ? POS_W'(1) : {POS_W{1'b1}});
         default: p = POS_W'($urandom());
      endcase
      return p;
   endfunction

   task automatic test_directed();
      send_read('0);
      send_insert('0, '0);
      send_insert({POS_W{1'b1}}, {FLAG_W{1'b1}});
      send_insert(31'd1000, 8'h01);
      send_insert(31'd1000, 8'h80);
      send_insert('0, 8'h55);
      send_insert(31'd999, 8'h02);
      for (int k = 0; k < 5; k++) send_read(IDX_W'(k));
      send_read({IDX_W{1'b1}});
      send_word(CMD_NOP, {POS_W{1'b1}}, {FLAG_W{1'b1}}, {IDX_W{1'b1}});
      send_word(CMD_NOP, '0, '0, '0);
      send_read(IDX_W'(1));
      send_clear();
      send_read('0);
      send_clear();
      send_insert(31'h4000_0000, 8'haa);
      send_read('0);
      wait_drained();
   endtask

   task automatic test_fill_to_capacity();
      send_clear();
      // descending run forces a shift of every held entry
      for (int k = 0; k < TABLE_DEPTH / 2; k++)
         send_insert(31'h7fff_fff0 - POS_W'(k * 3), FLAG_W'($urandom()));
      while (mirror_count < TABLE_DEPTH) send_insert(POS_W'($urandom()), FLAG_W'($urandom()));
      send_insert(31'h7fff_fff1, 8'h3c);
      send_insert(31'h7fff_fff0, 8'hc3);
      send_insert('0, 8'h01);
      send_read('0);
      send_read({IDX_W{1'b1}});
      repeat (8) send_read(IDX_W'($urandom()));
      send_clear();
      wait_drained();
   endtask

   task automatic test_long_hold();
      hold_request = 1'b1;
      gaps_on = 1'b0;
      repeat (24) begin
         if ($urandom_range(0, 1)) send_insert(pick_pos(), FLAG_W'($urandom()));
         else send_read(pick_index());
      end
      gaps_on = 1'b1;
      wait_drained();
   endtask

   task automatic test_random_sessions();
      int sent;
      int len;
      int roll;
      sent = 0;
      while (sent < 1450) begin
         for (int k = 0; k < POOL_SIZE; k++) pos_pool[k] = POS_W'($urandom());
         len = $urandom_range(50, 300);
         send_clear();
         sent++;
         repeat (len) begin
            roll = $urandom_range(0, 99);
            if (roll < 55) send_insert(pick_pos(), FLAG_W'($urandom()));
            else if (roll < 93) send_read(pick_index());
            else if (roll < 96) send_clear();
            else send_word(CMD_NOP, POS_W'($urandom()), FLAG_W'($urandom()),
                           IDX_W'($urandom()));
            sent++;
         end
         if ($urandom_range(0, 2) == 0) wait_drained();
      end
      wait_drained();
   endtask

   // receiver stall pattern, with a long hold on request
   initial begin : rsp_stall_gen
      int mode;
      int mode_left;
      int hold_left;
      mode = 0;
      mode_left = 0;
      hold_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_left = LONG_HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (mode_left == 0) begin
            mode = $urandom_range(0, 3);
            mode_left = $urandom_range(10, 80);
         end else begin
            mode_left--;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            case (mode)
               0: rsp_bus.ready <= 1'b1;
               1: rsp_bus.ready <= 1'($urandom_range(0, 1));
               2: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
               default: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      site_reply_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_replies.size() == 0) begin
            report_mismatch("unexpected word, status", 0, rsp_bus.status);
         end else begin
            want = expected_replies.pop_front();
            if (rsp_bus.status !== want.status)
               report_mismatch("status", want.status, rsp_bus.status);
            if (rsp_bus.entry_pos !== want.pos)
               report_mismatch("entry_pos", want.pos, rsp_bus.entry_pos);
            if (rsp_bus.entry_flag !== want.flag)
               report_mismatch("entry_flag", want.flag, rsp_bus.entry_flag);
            if (rsp_bus.entry_count !== want.count)
               report_mismatch("entry_count", want.count, rsp_bus.entry_count);
         end
      end
   end

   initial begin
      req_bus.valid <= 1'b0;
      req_bus.cmd <= CMD_NOP;
      req_bus.site_pos <= '0;
      req_bus.site_flag <= '0;
      req_bus.read_index <= '0;
      for (int k = 0; k < POOL_SIZE; k++) pos_pool[k] = POS_W'($urandom());
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_fill_to_capacity();
      test_long_hold();
      test_random_sessions();
      repeat (20) @(posedge clock);
      if (error_count == 0 && expected_replies.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
